// ===== src/assert_macros.svh =====
// Assertion macros shared by the region table RTL.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RMCS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("region table assertion failed");
`define RMCS_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("region table assertion failed");
`else
`define RMCS_ASSERT(lbl, clk, rstn, prop)
`define RMCS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== src/rmcs_pkg.sv =====
//------------------------------------------------------------------------------
// rmcs_pkg
// Types, constants and controller/datapath command structures for the
// region table block.
//------------------------------------------------------------------------------
`default_nettype none
package rmcs_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_CARVE  = 2'd1,
        REQ_SORT   = 2'd2,
        REQ_DUMP   = 2'd3
    } t_req;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] len;
        logic [15:0] kind;
    } t_region;

    typedef enum logic [1:0] {
        RD_AT_I,
        RD_AT_CNT,
        RD_AT_JM1
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_NEW,
        WR_SPLIT,
        WR_FRONT,
        WR_TAIL,
        WR_MOVE,
        WR_SHIFT,
        WR_KEY
    } t_wr_sel;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_OK,
        OUT_FULL,
        OUT_DUMP
    } t_out_sel;

    typedef struct packed {
        logic     load_req;
        logic     rd_en;
        t_rd_sel  rd_sel;
        t_wr_sel  wr_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     i_clr;
        logic     i_set1;
        logic     i_inc;
        logic     j_from_i;
        logic     j_dec;
        logic     load_key;
        logic     calc_end;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic i_ge_cnt;
        logic full;
        logic lt2;
        logic cnt_zero;
        logic covered;
        logic overlap;
        logic front;
        logic tail;
        logic j_zero;
        logic shift_gt;
        logic dump_last;
    } t_sts;

endpackage
`default_nettype wire

// ===== src/rmcs_ctrl.sv =====
//------------------------------------------------------------------------------
// rmcs_ctrl
// Request sequencer: walks the table for carve, sort and dump requests and
// drives the datapath one step per state.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rmcs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  rmcs_pkg::t_sts      i_sts,
    output rmcs_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_C_CHK,
        ST_C_CALC,
        ST_C_EVAL,
        ST_C_MOVE_RD,
        ST_C_MOVE_WR,
        ST_C_SPLIT2,
        ST_S_KEY_RD,
        ST_S_KEY_LD,
        ST_S_JCHK,
        ST_S_SHIFT,
        ST_S_NEXT,
        ST_D_RD,
        ST_D_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load_req = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_sts.req)
                    rmcs_pkg::REQ_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.out_sel = rmcs_pkg::OUT_FULL;
                        end else begin
                            o_cmd.wr_sel  = rmcs_pkg::WR_NEW;
                            o_cmd.cnt_inc = 1'b1;
                            o_cmd.out_sel = rmcs_pkg::OUT_OK;
                        end
                        n_state = ST_IDLE;
                    end
                    rmcs_pkg::REQ_CARVE: begin
                        o_cmd.i_clr = 1'b1;
                        n_state = ST_C_CHK;
                    end
                    rmcs_pkg::REQ_SORT: begin
                        if (i_sts.lt2) begin
                            o_cmd.out_sel = rmcs_pkg::OUT_OK;
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.i_set1 = 1'b1;
                            n_state = ST_S_KEY_RD;
                        end
                    end
                    rmcs_pkg::REQ_DUMP: begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.out_sel = rmcs_pkg::OUT_OK;
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.i_clr = 1'b1;
                            n_state = ST_D_RD;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_C_CHK: begin
                if (i_sts.i_ge_cnt) begin
                    // Walk finished: append the new range itself.
                    if (i_sts.full) begin
                        o_cmd.out_sel = rmcs_pkg::OUT_FULL;
                    end else begin
                        o_cmd.wr_sel  = rmcs_pkg::WR_NEW;
                        o_cmd.cnt_inc = 1'b1;
                        o_cmd.out_sel = rmcs_pkg::OUT_OK;
                    end
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = rmcs_pkg::RD_AT_I;
                    n_state = ST_C_CALC;
                end
            end
            ST_C_CALC: begin
                o_cmd.calc_end = 1'b1;
                n_state = ST_C_EVAL;
            end
            ST_C_EVAL: begin
                if (i_sts.covered) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state = ST_C_MOVE_RD;
                end else if (i_sts.overlap) begin
                    if (i_sts.front) begin
                        o_cmd.wr_sel = rmcs_pkg::WR_FRONT;
                        o_cmd.i_inc  = 1'b1;
                        n_state = ST_C_CHK;
                    end else if (i_sts.tail) begin
                        o_cmd.wr_sel = rmcs_pkg::WR_TAIL;
                        o_cmd.i_inc  = 1'b1;
                        n_state = ST_C_CHK;
                    end else if (i_sts.full) begin
                        o_cmd.out_sel = rmcs_pkg::OUT_FULL;
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.wr_sel  = rmcs_pkg::WR_SPLIT;
                        o_cmd.cnt_inc = 1'b1;
                        n_state = ST_C_SPLIT2;
                    end
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state = ST_C_CHK;
                end
            end
            ST_C_MOVE_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = rmcs_pkg::RD_AT_CNT;
                n_state = ST_C_MOVE_WR;
            end
            ST_C_MOVE_WR: begin
                // The moved entry lands in slot i, which is examined again.
                o_cmd.wr_sel = rmcs_pkg::WR_MOVE;
                n_state = ST_C_CHK;
            end
            ST_C_SPLIT2: begin
                o_cmd.wr_sel = rmcs_pkg::WR_TAIL;
                o_cmd.i_inc  = 1'b1;
                n_state = ST_C_CHK;
            end
            ST_S_KEY_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = rmcs_pkg::RD_AT_I;
                n_state = ST_S_KEY_LD;
            end
            ST_S_KEY_LD: begin
                o_cmd.load_key = 1'b1;
                o_cmd.j_from_i = 1'b1;
                n_state = ST_S_JCHK;
            end
            ST_S_JCHK: begin
                if (i_sts.j_zero) begin
                    o_cmd.wr_sel = rmcs_pkg::WR_KEY;
                    o_cmd.i_inc  = 1'b1;
                    n_state = ST_S_NEXT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = rmcs_pkg::RD_AT_JM1;
                    n_state = ST_S_SHIFT;
                end
            end
            ST_S_SHIFT: begin
                if (i_sts.shift_gt) begin
                    o_cmd.wr_sel = rmcs_pkg::WR_SHIFT;
                    o_cmd.j_dec  = 1'b1;
                    n_state = ST_S_JCHK;
                end else begin
                    o_cmd.wr_sel = rmcs_pkg::WR_KEY;
                    o_cmd.i_inc  = 1'b1;
                    n_state = ST_S_NEXT;
                end
            end
            ST_S_NEXT: begin
                if (i_sts.i_ge_cnt) begin
                    o_cmd.out_sel = rmcs_pkg::OUT_OK;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_S_KEY_RD;
                end
            end
            ST_D_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = rmcs_pkg::RD_AT_I;
                n_state = ST_D_OUT;
            end
            ST_D_OUT: begin
                o_cmd.out_sel = rmcs_pkg::OUT_DUMP;
                o_cmd.i_inc   = 1'b1;
                n_state = i_sts.dump_last ? ST_IDLE : ST_D_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RMCS_ASSERT(a_accept_goes_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `RMCS_NEVER(a_cnt_up_down, i_clk, i_rst_n, o_cmd.cnt_inc && o_cmd.cnt_dec)
    `RMCS_NEVER(a_grow_when_full, i_clk, i_rst_n, o_cmd.cnt_inc && i_sts.full)

endmodule
`default_nettype wire

// ===== src/rmcs_dp.sv =====
//------------------------------------------------------------------------------
// rmcs_dp
// Region table datapath: entry memory, count and walk indexes, overlap
// compares and the result registers.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rmcs_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [1:0]     i_req_type,
    input  wire logic [15:0]    i_region_kind,
    input  wire logic [63:0]    i_region_start,
    input  wire logic [63:0]    i_region_size,
    input  rmcs_pkg::t_cmd      i_cmd,
    output rmcs_pkg::t_sts      o_sts,
    output logic                o_strobe,
    output logic                o_status,
    output logic [5:0]          o_entry_count,
    output logic                o_entry_valid,
    output logic [63:0]         o_dump_base,
    output logic [63:0]         o_dump_length,
    output logic [15:0]         o_dump_kind,
    output logic                o_last
);

    localparam int IW = rmcs_pkg::IDX_W;
    localparam int CW = rmcs_pkg::CNT_W;

    rmcs_pkg::t_region r_mem [rmcs_pkg::TABLE_DEPTH];

    rmcs_pkg::t_req    r_req;
    logic [15:0]       r_kind;
    logic [63:0]       r_start;
    logic [63:0]       r_stop;
    logic [63:0]       r_size;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_j;
    rmcs_pkg::t_region r_rd;
    rmcs_pkg::t_region r_key;
    logic [63:0]       r_end;

    logic              r_strobe;
    logic              r_status;
    logic              r_valid;
    logic [63:0]       r_base_o;
    logic [63:0]       r_len_o;
    logic [15:0]       r_kind_o;
    logic              r_last;

    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    rmcs_pkg::t_region wr_data;
    logic [CW-1:0]     j_m1;

    assign j_m1 = r_j - CW'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            rmcs_pkg::RD_AT_I:   rd_addr = r_i[IW-1:0];
            rmcs_pkg::RD_AT_CNT: rd_addr = r_count[IW-1:0];
            rmcs_pkg::RD_AT_JM1: rd_addr = j_m1[IW-1:0];
            default:             rd_addr = r_i[IW-1:0];
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_i[IW-1:0];
        wr_data = r_rd;
        unique case (i_cmd.wr_sel)
            rmcs_pkg::WR_NONE: begin
                wr_en = 1'b0;
            end
            rmcs_pkg::WR_NEW: begin
                wr_addr = r_count[IW-1:0];
                wr_data = '{base: r_start, len: r_size, kind: r_kind};
            end
            rmcs_pkg::WR_SPLIT: begin
                wr_addr = r_count[IW-1:0];
                wr_data = '{base: r_stop, len: r_end - r_stop, kind: r_rd.kind};
            end
            rmcs_pkg::WR_FRONT: begin
                // Remaining length is end - stop.
                wr_data = '{base: r_stop, len: r_end - r_stop, kind: r_rd.kind};
            end
            rmcs_pkg::WR_TAIL: begin
                wr_data = '{base: r_rd.base, len: r_start - r_rd.base, kind: r_rd.kind};
            end
            rmcs_pkg::WR_MOVE: begin
                wr_data = r_rd;
            end
            rmcs_pkg::WR_SHIFT: begin
                wr_addr = r_j[IW-1:0];
                wr_data = r_rd;
            end
            rmcs_pkg::WR_KEY: begin
                wr_addr = r_j[IW-1:0];
                wr_data = r_key;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= rmcs_pkg::t_req'(i_req_type);
            r_kind  <= i_region_kind;
            r_start <= i_region_start;
            r_size  <= i_region_size;
            r_stop  <= i_region_start + i_region_size;
        end
        if (i_cmd.calc_end) begin
            r_end <= r_rd.base + r_rd.len;
        end
        if (i_cmd.load_key) begin
            r_key <= r_rd;
        end
        if (i_cmd.j_from_i) begin
            r_j <= r_i;
        end else if (i_cmd.j_dec) begin
            r_j <= j_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_i     <= '0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            priority if (i_cmd.i_clr) begin
                r_i <= '0;
            end else if (i_cmd.i_set1) begin
                r_i <= CW'(1);
            end else if (i_cmd.i_inc) begin
                r_i <= r_i + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.out_sel != rmcs_pkg::OUT_NONE);
        end
        unique case (i_cmd.out_sel)
            rmcs_pkg::OUT_OK, rmcs_pkg::OUT_FULL: begin
                r_status <= (i_cmd.out_sel == rmcs_pkg::OUT_FULL);
                r_valid  <= 1'b0;
                r_base_o <= '0;
                r_len_o  <= '0;
                r_kind_o <= '0;
                r_last   <= 1'b1;
            end
            rmcs_pkg::OUT_DUMP: begin
                r_status <= 1'b0;
                r_valid  <= 1'b1;
                r_base_o <= r_rd.base;
                r_len_o  <= r_rd.len;
                r_kind_o <= r_rd.kind;
                r_last   <= o_sts.dump_last;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.req       = r_req;
        o_sts.i_ge_cnt  = (r_i >= r_count);
        o_sts.full      = (r_count >= CW'(rmcs_pkg::TABLE_DEPTH));
        o_sts.lt2       = (r_count < CW'(2));
        o_sts.cnt_zero  = (r_count == '0);
        o_sts.covered   = (r_rd.base >= r_start) && (r_end <= r_stop);
        o_sts.overlap   = (r_end > r_start) && (r_stop > r_rd.base);
        o_sts.front     = (r_start <= r_rd.base);
        o_sts.tail      = (r_stop >= r_end);
        o_sts.j_zero    = (r_j == '0);
        o_sts.shift_gt  = (r_rd.base > r_key.base);
        o_sts.dump_last = ({1'b0, r_i} + (CW + 1)'(1) == {1'b0, r_count});
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_entry_count = 6'(r_count);
    assign o_entry_valid = r_valid;
    assign o_dump_base   = r_base_o;
    assign o_dump_length = r_len_o;
    assign o_dump_kind   = r_kind_o;
    assign o_last        = r_last;

    `RMCS_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(rmcs_pkg::TABLE_DEPTH))
    `RMCS_NEVER(a_index_bound, i_clk, i_rst_n, r_i > r_count)
    `RMCS_NEVER(a_push_full, i_clk, i_rst_n,
        ((i_cmd.wr_sel == rmcs_pkg::WR_NEW) || (i_cmd.wr_sel == rmcs_pkg::WR_SPLIT)) && o_sts.full)

endmodule
`default_nettype wire

// ===== src/region_map_carve_and_sort.sv =====
//------------------------------------------------------------------------------
// region_map_carve_and_sort
// Table of up to 32 typed address regions with append, carve-insert,
// stable sort by base and dump requests.
//------------------------------------------------------------------------------
// Usage: a request is transferred when start is high and busy is low; its
// fields are captured at that edge. Results come out on o_* ports, one per
// cycle of o_strobe, and the receiver cannot stall them. Append, carve and
// sort give one result with o_last set; dump gives one result per region
// (one empty result for an empty table), o_last on the final one.
// Steps: append writes the new entry from the dispatch state. Carve reads
// and compares each entry in turn; a covered entry is replaced by the last
// entry, and a split one keeps its lower part and adds its upper part as a
// new entry. Sort is an insertion sort that shifts larger entries up behind
// each key. Dump reads each entry and then gives it as a result. busy falls
// with the final result, so the next request may follow in that cycle.
// Reset (synchronous, active low) empties the table; the entry memory is
// not cleared and needs no clearing pass.
//------------------------------------------------------------------------------
`default_nettype none
module region_map_carve_and_sort (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_region_kind,
    input  wire logic [63:0] i_region_start,
    input  wire logic [63:0] i_region_size,
    output logic             o_strobe,
    output logic             o_status,
    output logic [5:0]       o_entry_count,
    output logic             o_entry_valid,
    output logic [63:0]      o_dump_base,
    output logic [63:0]      o_dump_length,
    output logic [15:0]      o_dump_kind,
    output logic             o_last
);

    rmcs_pkg::t_cmd cmd;
    rmcs_pkg::t_sts sts;

    rmcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rmcs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_region_kind  (i_region_kind),
        .i_region_start (i_region_start),
        .i_region_size  (i_region_size),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_entry_valid  (o_entry_valid),
        .o_dump_base    (o_dump_base),
        .o_dump_length  (o_dump_length),
        .o_dump_kind    (o_dump_kind),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire
